// ----- rtl/col_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the compacting ordered list.
// No dependencies; imported by col_ctrl, col_dp and compacting_ordered_list.
package col_pkg;

	localparam int COL_CAPACITY   = 64;
	localparam int COL_WORD_WIDTH = 32;

	// fixed field widths of the stream payload
	localparam int OP_W      = 3;
	localparam int IDX_W     = 6;
	localparam int VAL_W     = 32;
	localparam int CNT_OUT_W = 7;
	localparam int ST_W      = 2;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;
	localparam int S_PAD_W   = S_TDATA_W - IDX_W - VAL_W;
	localparam int M_PAD_W   = M_TDATA_W - VAL_W - CNT_OUT_W;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND       = 3'd0,
		OP_REMOVE_VALUE = 3'd1,
		OP_REMOVE_INDEX = 3'd2,
		OP_OVERWRITE    = 3'd3,
		OP_READ         = 3'd4,
		OP_SEARCH       = 3'd5,
		OP_CLEAR        = 3'd6
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} st_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;        // latch request fields, clear result
		logic append;         // write word at end, count + 1
		logic overwrite;      // write word at index
		logic read_idx;       // issue memory read at index
		logic take_rdata;     // result data <= read data
		logic take_word;      // result data <= request word
		logic scan_start;     // pointer to zero for a scan
		logic scan_step;      // one search read
		logic shift_start;    // pointer to position + 1 for a compaction
		logic shift_from_hit; // position is the matched entry, not the index
		logic shift_step;     // one compaction read / write
		logic dec_count;      // count - 1 after compaction
		logic clear;          // count to zero
		logic set_st;         // load result status
		st_t  st;
		logic load_out;       // move result into output register
	} col_cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_t  op;
		logic idx_ok;
		logic full;
		logic hit;
		logic scan_end;
		logic shift_end;
	} col_stat_t;

endpackage

// ----- rtl/col_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the compacting ordered list: handshakes and per-operation steps.
// Depends on col_pkg; drives col_dp through col_cmd_t.
module col_ctrl import col_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  col_stat_t stat,
	output col_cmd_t  cmd
);

	typedef enum logic [2:0] {
		IDLE,
		EXEC,
		READ_WAIT,
		SCAN,
		SHIFT,
		FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = EXEC;
				end
			end
			EXEC: begin
				state_d = FIN;
				case (stat.op)
					OP_APPEND: begin
						if (stat.full) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_FULL;
						end else begin
							cmd.append = 1'b1;
						end
					end
					OP_REMOVE_VALUE, OP_SEARCH: begin
						cmd.scan_start = 1'b1;
						state_d        = SCAN;
					end
					OP_REMOVE_INDEX: begin
						if (stat.idx_ok) begin
							cmd.shift_start = 1'b1;
							state_d         = SHIFT;
						end else begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_MISS;
						end
					end
					OP_OVERWRITE: begin
						if (stat.idx_ok) begin
							cmd.overwrite = 1'b1;
						end else begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_MISS;
						end
					end
					OP_READ: begin
						if (stat.idx_ok) begin
							cmd.read_idx = 1'b1;
							state_d      = READ_WAIT;
						end else begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_MISS;
						end
					end
					OP_CLEAR: begin
						cmd.clear = 1'b1;
					end
					default: begin
						// unused code: no change, ok
					end
				endcase
			end
			READ_WAIT: begin
				cmd.take_rdata = 1'b1;
				state_d        = FIN;
			end
			SCAN: begin
				if (stat.hit) begin
					if (stat.op == OP_SEARCH) begin
						cmd.take_word = 1'b1;
						state_d       = FIN;
					end else begin
						cmd.shift_start    = 1'b1;
						cmd.shift_from_hit = 1'b1;
						state_d            = SHIFT;
					end
				end else if (stat.scan_end) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_MISS;
					state_d    = FIN;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			SHIFT: begin
				if (stat.shift_end) begin
					cmd.dec_count = 1'b1;
					state_d       = FIN;
				end else begin
					cmd.shift_step = 1'b1;
				end
			end
			FIN: begin
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// one request in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("col_ctrl: request accepted while another is in work");

	// a finished result always shows on the output
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_tvalid)
		else $error("col_ctrl: result loaded but not presented");

endmodule

// ----- rtl/col_dp.sv -----
`timescale 1ns / 1ps
// Datapath: entry memory, count, scan/compaction pointer, result registers.
// Depends on col_pkg; commanded by col_ctrl.
module col_dp import col_pkg::*; #(
	parameter int CAPACITY   = COL_CAPACITY,
	parameter int WORD_WIDTH = COL_WORD_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  col_cmd_t             cmd,
	output col_stat_t            stat,
	input  op_t                  in_op,
	input  logic [IDX_W-1:0]     in_idx,
	input  logic [VAL_W-1:0]     in_value,
	output logic [VAL_W-1:0]     out_data,
	output logic [CNT_OUT_W-1:0] out_count,
	output st_t                  out_st
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > IDX_W) ? CW : IDX_W;

	logic [WORD_WIDTH-1:0] mem [CAPACITY];

	op_t                   op_q;
	logic [IDX_W-1:0]      idx_q;
	logic [WORD_WIDTH-1:0] word_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         ptr_q;
	logic                  rd_vld_s1;
	logic [CW-1:0]         rd_addr_s1;
	logic [WORD_WIDTH-1:0] rdata_s1;
	logic [VAL_W-1:0]      data_q;
	st_t                   st_q;

	logic                  step;
	logic                  ptr_live;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [WORD_WIDTH-1:0] wr_data;
	logic [CW-1:0]         shift_pos;

	assign step     = cmd.scan_step || cmd.shift_step;
	assign ptr_live = (ptr_q < count_q);

	assign stat.op        = op_q;
	assign stat.idx_ok    = (XW'(idx_q) < XW'(count_q));
	assign stat.full      = (count_q == CW'(CAPACITY));
	assign stat.hit       = rd_vld_s1 && (rdata_s1 == word_q);
	assign stat.scan_end  = !rd_vld_s1 && !ptr_live;
	assign stat.shift_end = !rd_vld_s1 && !ptr_live;

	// single read port, registered data
	assign rd_en   = cmd.read_idx || (step && ptr_live);
	assign rd_addr = cmd.read_idx ? AW'(idx_q) : AW'(ptr_q);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// single write port; compaction writes each entry one slot down
	assign wr_en = cmd.append || cmd.overwrite || (cmd.shift_step && rd_vld_s1);

	always_comb begin
		wr_addr = AW'(rd_addr_s1 - CW'(1));
		wr_data = rdata_s1;
		if (cmd.append) begin
			wr_addr = AW'(count_q);
			wr_data = word_q;
		end else if (cmd.overwrite) begin
			wr_addr = AW'(idx_q);
			wr_data = word_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign shift_pos = cmd.shift_from_hit ? rd_addr_s1 : CW'(idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ptr_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_addr_s1 <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.append) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.dec_count) begin
				count_q <= count_q - CW'(1);
			end

			if (cmd.scan_start) begin
				ptr_q     <= '0;
				rd_vld_s1 <= 1'b0;
			end else if (cmd.shift_start) begin
				ptr_q     <= shift_pos + CW'(1);
				rd_vld_s1 <= 1'b0;
			end else if (step) begin
				rd_vld_s1 <= ptr_live;
				if (ptr_live) begin
					rd_addr_s1 <= ptr_q;
					ptr_q      <= ptr_q + CW'(1);
				end
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_op;
			idx_q  <= in_idx;
			word_q <= WORD_WIDTH'(in_value);
			data_q <= '0;
			st_q   <= ST_OK;
		end
		if (cmd.set_st) begin
			st_q <= cmd.st;
		end
		if (cmd.take_rdata) begin
			data_q <= VAL_W'(rdata_s1);
		end else if (cmd.take_word) begin
			data_q <= VAL_W'(word_q);
		end
		if (cmd.load_out) begin
			out_data  <= data_q;
			out_count <= CNT_OUT_W'(count_q);
			out_st    <= st_q;
		end
	end

	a_append_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |=> (count_q == $past(count_q) + CW'(1)))
		else $error("col_dp: append did not advance the count");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> (ptr_q <= count_q))
		else $error("col_dp: pointer ran past the held entries");

	a_dec_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec_count |-> (count_q != '0))
		else $error("col_dp: removal from an empty list");

endmodule

// ----- rtl/compacting_ordered_list.sv -----
`timescale 1ns / 1ps
// Top level of the compacting ordered list: controller plus datapath.
// Depends on col_pkg, col_ctrl and col_dp.
//
// Use: each transfer on the s_ channel is one request (append, remove by
// value, remove at index, overwrite, read, search, clear) selected by
// s_tuser. Each request gives exactly one transfer on the m_ channel with
// the data word, the entry count after the request and a status code.
// Requests are handled one at a time, in order.
//
// Steps from request transfer to result valid:
//   append, overwrite, clear, unused code, any refused request: executed
//   at once; read: one memory read at the index.
//   search: a scan from entry 0 up to the match or the end of the list.
//   remove by value: the same scan, then a compaction of the entries
//   behind the match; a miss ends after the scan, as a search miss does.
//   remove at index: a compaction of the entries behind the index; none
//   move when the last entry goes.
// The block takes the next request in the cycle after the result is
// loaded. The scan and the compaction move one entry per cycle through
// the single read and single write port of the entry memory.
// Reset empties the list at once; no clearing pass. If the receiver
// stalls, the result waits in the output register while the next request
// is accepted and worked; that request holds at its end until the output
// register is free.
module compacting_ordered_list import col_pkg::*; #(
	parameter int CAPACITY   = COL_CAPACITY,
	parameter int WORD_WIDTH = COL_WORD_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // index[5:0], value[37:6], zero pad
	input  logic [OP_W-1:0]      s_tuser,  // operation[2:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // data[31:0], entry_count[38:32], zero pad
	output logic [ST_W-1:0]      m_tuser   // status[1:0]
);

	col_cmd_t              cmd;
	col_stat_t             stat;
	logic [VAL_W-1:0]      out_data;
	logic [CNT_OUT_W-1:0]  out_count;
	st_t                   out_st;

	col_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	col_dp #(
		.CAPACITY   (CAPACITY),
		.WORD_WIDTH (WORD_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_op     (op_t'(s_tuser)),
		.in_idx    (s_tdata[IDX_W-1:0]),
		.in_value  (s_tdata[IDX_W+VAL_W-1:IDX_W]),
		.out_data  (out_data),
		.out_count (out_count),
		.out_st    (out_st)
	);

	assign m_tdata = {{M_PAD_W{1'b0}}, out_count, out_data};
	assign m_tuser = out_st;

endmodule

// ----- test/compacting_ordered_list_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for compacting_ordered_list: directed, full-list, backpressure and
// random request traffic, each result checked against a behavioral list kept in the bench.
// Depends on col_pkg and the compacting_ordered_list RTL.
module compacting_ordered_list_tb;
	import col_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;   // no operation assigned; block ignores it
	localparam int MAX_CYCLES = 1_000_000;
	localparam int MAX_PRINTS = 50;

	typedef struct {
		logic [VAL_W-1:0]     data;
		logic [CNT_OUT_W-1:0] count;
		st_t                  status;
	} list_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [OP_W-1:0]      s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [ST_W-1:0]      m_tuser;

	logic                 rx_hold = 1'b0;   // long receiver hold-off
	int                   tx_idle_pct = 0;
	int                   rx_stall_pct = 0;

	logic [VAL_W-1:0]     list_entries[$];  // bench copy of the list contents
	list_result_t         pending_results[$];

	int                   error_count = 0;
	int                   request_count = 0;
	int                   result_count = 0;
	int                   full_count = 0;
	int                   miss_count = 0;
	int                   cycle_count = 0;

	compacting_ordered_list dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= MAX_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results pending", cycle_count,
				pending_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Apply one request to the bench list and return the result it should produce.
	function automatic list_result_t apply_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
			logic [VAL_W-1:0] word);
		list_result_t r;
		int hit_pos;
		r.data = '0;
		r.status = ST_OK;
		hit_pos = -1;
		foreach (list_entries[k])
			if (hit_pos < 0 && list_entries[k] == word)
				hit_pos = k;
		case (op)
			OP_APPEND: begin
				if (list_entries.size() >= COL_CAPACITY)
					r.status = ST_FULL;
				else
					list_entries.push_back(word);
			end
			OP_REMOVE_VALUE: begin
				if (hit_pos >= 0)
					list_entries.delete(hit_pos);
				else
					r.status = ST_MISS;
			end
			OP_REMOVE_INDEX: begin
				if (idx < list_entries.size())
					list_entries.delete(idx);
				else
					r.status = ST_MISS;
			end
			OP_OVERWRITE: begin
				if (idx < list_entries.size())
					list_entries[idx] = word;
				else
					r.status = ST_MISS;
			end
			OP_READ: begin
				if (idx < list_entries.size())
					r.data = list_entries[idx];
				else
					r.status = ST_MISS;
			end
			OP_SEARCH: begin
				if (hit_pos >= 0)
					r.data = list_entries[hit_pos];
				else
					r.status = ST_MISS;
			end
			OP_CLEAR: list_entries.delete();
			default: ;
		endcase
		r.count = CNT_OUT_W'(list_entries.size());
		if (r.status == ST_FULL)
			full_count++;
		if (r.status == ST_MISS)
			miss_count++;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// Offer one request, hold it until the transfer, then log its expected result.
	// tvalid stays high after the transfer; the next call lowers it only for a gap.
	task automatic send_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
			logic [VAL_W-1:0] word);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{S_PAD_W{1'b0}}, word, idx};
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(apply_request(op, idx, word));
		request_count++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls, overridden by the long hold-off.
	always @(posedge clk) begin
		if (rx_hold)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Result checker: every transfer on the output side must match the oldest expectation.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			result_count++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", m_tdata[VAL_W-1:0], '0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[VAL_W-1:0] !== want.data)
					report_mismatch("data", m_tdata[VAL_W-1:0], want.data);
				if (m_tdata[VAL_W +: CNT_OUT_W] !== want.count)
					report_mismatch("entry count", VAL_W'(m_tdata[VAL_W +: CNT_OUT_W]),
						VAL_W'(want.count));
				if (m_tuser !== want.status)
					report_mismatch("status", VAL_W'(m_tuser), VAL_W'(want.status));
			end
		end
	end

	// Empty-list misses, value extremes, duplicates, every opcode including the unused one.
	task automatic test_directed_ops();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		send_request(OP_READ, 6'd0, '0);
		send_request(OP_REMOVE_INDEX, 6'd0, '0);
		send_request(OP_REMOVE_VALUE, 6'd0, 32'd5);
		send_request(OP_SEARCH, 6'd0, 32'd5);
		send_request(OP_OVERWRITE, 6'd0, 32'h1234_5678);
		send_request(OP_APPEND, 6'd63, 32'h0000_0000);
		send_request(OP_APPEND, 6'd0, 32'hFFFF_FFFF);
		send_request(OP_APPEND, 6'd0, 32'd5);
		send_request(OP_APPEND, 6'd0, 32'h0000_0000);        // duplicate of entry 0
		send_request(OP_SEARCH, 6'd0, 32'h0000_0000);        // match, data is zero
		send_request(OP_SEARCH, 6'd0, 32'hFFFF_FFFF);
		send_request(OP_REMOVE_VALUE, 6'd0, 32'h0000_0000);  // only the first copy goes
		send_request(OP_READ, 6'd0, '0);
		send_request(OP_READ, 6'd2, '0);
		send_request(OP_READ, 6'd63, '0);
		send_request(OP_OVERWRITE, 6'd1, 32'hA5A5_A5A5);
		send_request(OP_OVERWRITE, 6'd3, 32'h5A5A_5A5A);     // index equals count
		send_request(OP_REMOVE_INDEX, 6'd2, '0);             // last entry, no shift
		send_request(OP_UNUSED, 6'd63, 32'hFFFF_FFFF);
		send_request(OP_REMOVE_INDEX, 6'd0, '0);
		send_request(OP_CLEAR, 6'd0, '0);
		send_request(OP_READ, 6'd0, '0);
		drain_results();
	endtask

	// Fill to capacity, refuse one more, then work on the full list.
	task automatic test_capacity_limit();
		logic [VAL_W-1:0] last_word;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		send_request(OP_CLEAR, 6'd0, '0);
		for (int i = 0; i < COL_CAPACITY; i++)
			send_request(OP_APPEND, 6'($urandom_range(63)), $urandom());
		last_word = list_entries[COL_CAPACITY-1];
		send_request(OP_APPEND, 6'd0, 32'hDEAD_BEEF);
		send_request(OP_READ, 6'd63, '0);
		send_request(OP_SEARCH, 6'd0, last_word);            // longest scan
		send_request(OP_REMOVE_VALUE, 6'd0, list_entries[0]); // longest compaction
		send_request(OP_REMOVE_INDEX, 6'd0, '0);
		send_request(OP_APPEND, 6'd0, 32'h0000_0001);
		send_request(OP_APPEND, 6'd0, 32'h8000_0000);
		send_request(OP_APPEND, 6'd0, 32'h7FFF_FFFF);          // refused, the list is full again
		send_request(OP_REMOVE_INDEX, 6'd63, '0);
		send_request(OP_CLEAR, 6'd0, '0);
		drain_results();
	endtask

	task automatic send_random_request(bit grow);
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] word;
		int held;
		int sel;
		held = list_entries.size();
		if ($urandom_range(99) < (grow ? 50 : 18)) begin
			op = OP_APPEND;
		end else begin
			sel = $urandom_range(999);
			if (sel < 170)      op = OP_REMOVE_VALUE;
			else if (sel < 340) op = OP_REMOVE_INDEX;
			else if (sel < 510) op = OP_OVERWRITE;
			else if (sel < 700) op = OP_READ;
			else if (sel < 950) op = OP_SEARCH;
			else if (sel < 990) op = OP_UNUSED;
			else                op = OP_CLEAR;
		end
		// mostly valid positions and values already held, some misses
		if (held > 0 && $urandom_range(9) < 8)
			idx = IDX_W'($urandom_range(held - 1));
		else
			idx = IDX_W'($urandom_range(63));
		if (held > 0 && $urandom_range(9) < 6)
			word = list_entries[$urandom_range(held - 1)];
		else if ($urandom_range(1))
			word = $urandom_range(7);   // small pool breeds duplicates
		else
			word = $urandom();
		send_request(op, idx, word);
	endtask

	// Output held off for a long stretch while requests keep coming, so the input stalls.
	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		fork
			begin
				rx_hold <= 1'b1;
				repeat (400) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		for (int i = 0; i < 24; i++)
			send_random_request(1'b1);
		drain_results();
	endtask

	task automatic run_random_phase(int n_items, int tx_pct, int rx_pct);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		for (int i = 0; i < n_items; i++)
			send_random_request(((i / 120) % 2) == 0);
		drain_results();
	endtask

	task automatic test_random_traffic();
		run_random_phase(440, 0, 0);
		run_random_phase(420, 85, 0);
		run_random_phase(420, 0, 85);
		run_random_phase(440, 18, 18);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_capacity_limit();
		test_output_backpressure();
		test_random_traffic();
		repeat (100) @(posedge clk);
		$display("Checked %0d results for %0d requests (%0d refused full, %0d misses).",
			result_count, request_count, full_count, miss_count);
		$display("Ran directed ops, a full list, a long output hold-off and four idle mixes.");
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
